/* hw/rtl/assert_macros.svh */
// Assertion helpers used by the checker in fpdr_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/fpdr_pkg.sv */
package fpdr_pkg;

    // Lead bytes
    localparam logic [7:0] LEAD_SHORT = 8'hC1;
    localparam logic [7:0] LEAD_LONG  = 8'hC2;

    // Header sizes
    localparam logic [15:0] HDR_SHORT = 16'd3;
    localparam logic [15:0] HDR_LONG  = 16'd4;

    // Register map (byte address bit 2 picks the register)
    localparam logic REG_MAX_LEN   = 1'b0;
    localparam logic REG_CLIENT_ID = 1'b1;
    localparam logic [15:0] MAX_LEN_RESET = 16'd8192;

    // Destination queues
    localparam logic [1:0] Q_MAIN = 2'd0;
    localparam logic [1:0] Q_F6   = 2'd1;
    localparam logic [1:0] Q_52   = 2'd2;
    localparam logic [1:0] Q_13   = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_LEAD = 2'd1;
    localparam logic [1:0] ERR_LEN  = 2'd2;

    typedef enum logic [5:0] {
        PH_LEAD = 6'b000001,
        PH_LEN8 = 6'b000010,
        PH_LENH = 6'b000100,
        PH_LENL = 6'b001000,
        PH_CODE = 6'b010000,
        PH_BODY = 6'b100000
    } phase_t;

    // Group of result beats caused by one input byte
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic [1:0]      dest;
        logic [7:0]      code;
        logic [15:0]     len;
        logic            has_first;
        logic            has_last;
        logic [1:0]      err;
    } burst_t;

    function automatic logic [1:0] route_of(input logic [7:0] c);
        logic [1:0] q;
        q = Q_MAIN;
        case (c) inside
            8'h52, 8'h54, 8'h55: q = Q_52;
            8'hF6, 8'hF7:        q = Q_F6;
            8'h13, 8'h14:        q = Q_13;
            default:             q = Q_MAIN;
        endcase
        return q;
    endfunction

endpackage

/* hw/rtl/fpdr_parser.sv */
module fpdr_parser (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            rx_byte,
    input  logic                  chunk_end,
    input  logic [15:0]           max_packet_len,
    output logic                  burst_load,
    output fpdr_pkg::burst_t      burst
);

    fpdr_pkg::phase_t phase_reg, phase_next;
    logic        discard_reg, discard_next;
    logic [7:0]  hh0_reg, hh0_next;
    logic [7:0]  hh1_reg, hh1_next;
    logic [7:0]  hh2_reg, hh2_next;
    logic [15:0] frame_len_reg, frame_len_next;
    logic [15:0] left_reg, left_next;
    logic [1:0]  route_reg, route_next;
    logic [7:0]  code_reg, code_next;

    logic        fail_en;
    logic [1:0]  fail_err;
    logic [15:0] fail_len;
    logic        is_long;
    logic [15:0] len_new;
    logic [15:0] left_new;
    logic [1:0]  route_new;

    // Decode one byte against the current phase
    always_comb
    begin
        phase_next     = phase_reg;
        discard_next   = discard_reg;
        hh0_next       = hh0_reg;
        hh1_next       = hh1_reg;
        hh2_next       = hh2_reg;
        frame_len_next = frame_len_reg;
        left_next      = left_reg;
        route_next     = route_reg;
        code_next      = code_reg;
        burst          = '0;
        burst_load     = 1'b0;
        fail_en        = 1'b0;
        fail_err       = fpdr_pkg::ERR_NONE;
        fail_len       = '0;
        is_long        = (hh0_reg == fpdr_pkg::LEAD_LONG);
        len_new        = '0;
        left_new       = '0;
        route_new      = fpdr_pkg::route_of(rx_byte);

        if (discard_reg)
        begin
            // drop bytes until the chunk ends
            if (chunk_end)
            begin
                discard_next = 1'b0;
                phase_next   = fpdr_pkg::PH_LEAD;
            end
        end
        else
        begin
            unique case (phase_reg)
                fpdr_pkg::PH_LEN8:
                begin
                    hh1_next       = rx_byte;
                    len_new        = {8'd0, rx_byte};
                    frame_len_next = len_new;
                    if (len_new < fpdr_pkg::HDR_SHORT || len_new > max_packet_len)
                    begin
                        fail_en  = 1'b1;
                        fail_err = fpdr_pkg::ERR_LEN;
                        fail_len = len_new;
                    end
                    else
                    begin
                        phase_next = fpdr_pkg::PH_CODE;
                    end
                end
                fpdr_pkg::PH_LENH:
                begin
                    hh1_next   = rx_byte;
                    phase_next = fpdr_pkg::PH_LENL;
                end
                fpdr_pkg::PH_LENL:
                begin
                    hh2_next       = rx_byte;
                    len_new        = {hh1_reg, rx_byte};
                    frame_len_next = len_new;
                    if (len_new < fpdr_pkg::HDR_LONG || len_new > max_packet_len)
                    begin
                        fail_en  = 1'b1;
                        fail_err = fpdr_pkg::ERR_LEN;
                        fail_len = len_new;
                    end
                    else
                    begin
                        phase_next = fpdr_pkg::PH_CODE;
                    end
                end
                fpdr_pkg::PH_CODE:
                begin
                    // release the held header together with the head code
                    left_new   = frame_len_reg -
                                 (is_long ? fpdr_pkg::HDR_LONG : fpdr_pkg::HDR_SHORT);
                    code_next  = rx_byte;
                    route_next = route_new;
                    left_next  = left_new;
                    burst_load = 1'b1;
                    if (is_long)
                    begin
                        burst.bytes    = {rx_byte, hh2_reg, hh1_reg, hh0_reg};
                        burst.last_idx = 2'd3;
                    end
                    else
                    begin
                        burst.bytes    = {8'd0, rx_byte, hh1_reg, hh0_reg};
                        burst.last_idx = 2'd2;
                    end
                    burst.dest      = route_new;
                    burst.code      = rx_byte;
                    burst.len       = frame_len_reg;
                    burst.has_first = 1'b1;
                    burst.has_last  = (left_new == '0);
                    burst.err       = fpdr_pkg::ERR_NONE;
                    phase_next      = (left_new == '0) ? fpdr_pkg::PH_LEAD
                                                       : fpdr_pkg::PH_BODY;
                end
                fpdr_pkg::PH_BODY:
                begin
                    left_new        = left_reg - 16'd1;
                    left_next       = left_new;
                    burst_load      = 1'b1;
                    burst.bytes     = {24'd0, rx_byte};
                    burst.last_idx  = 2'd0;
                    burst.dest      = route_reg;
                    burst.code      = code_reg;
                    burst.len       = frame_len_reg;
                    burst.has_first = 1'b0;
                    burst.has_last  = (left_new == '0);
                    burst.err       = fpdr_pkg::ERR_NONE;
                    if (left_new == '0)
                    begin
                        phase_next = fpdr_pkg::PH_LEAD;
                    end
                end
                default:
                begin
                    // expect a lead byte
                    if (rx_byte == fpdr_pkg::LEAD_SHORT)
                    begin
                        hh0_next   = rx_byte;
                        phase_next = fpdr_pkg::PH_LEN8;
                    end
                    else if (rx_byte == fpdr_pkg::LEAD_LONG)
                    begin
                        hh0_next   = rx_byte;
                        phase_next = fpdr_pkg::PH_LENH;
                    end
                    else
                    begin
                        fail_en    = 1'b1;
                        fail_err   = fpdr_pkg::ERR_LEAD;
                        fail_len   = '0;
                        phase_next = fpdr_pkg::PH_LEAD;
                    end
                end
            endcase

            // report the error and drop the rest of the chunk
            if (fail_en)
            begin
                burst_load      = 1'b1;
                burst.bytes     = {24'd0, rx_byte};
                burst.last_idx  = 2'd0;
                burst.dest      = fpdr_pkg::Q_MAIN;
                burst.code      = '0;
                burst.len       = fail_len;
                burst.has_first = 1'b0;
                burst.has_last  = 1'b0;
                burst.err       = fail_err;
                phase_next      = fpdr_pkg::PH_LEAD;
                discard_next    = !chunk_end;
            end
        end
    end

    // Advance control state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= fpdr_pkg::PH_LEAD;
            discard_reg   <= 1'b0;
            frame_len_reg <= '0;
            left_reg      <= '0;
            route_reg     <= fpdr_pkg::Q_MAIN;
            code_reg      <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            discard_reg   <= discard_next;
            frame_len_reg <= frame_len_next;
            left_reg      <= left_next;
            route_reg     <= route_next;
            code_reg      <= code_next;
        end
    end

    // Hold header bytes
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            hh0_reg <= hh0_next;
            hh1_reg <= hh1_next;
            hh2_reg <= hh2_next;
        end
    end

endmodule

/* hw/rtl/fpdr_emitter.sv */
module fpdr_emitter (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  fpdr_pkg::burst_t      burst,
    output logic                  free,
    output logic                  valid,
    input  logic                  ready,
    output logic [7:0]            out_byte,
    output logic [1:0]            dest_queue,
    output logic [7:0]            head_code,
    output logic [15:0]           packet_len,
    output logic                  first_of_packet,
    output logic                  last_of_packet,
    output logic [1:0]            error_code
);

    fpdr_pkg::burst_t burst_reg;
    logic       busy_reg;
    logic [1:0] idx_reg;
    logic       final_beat;
    logic       take;

    assign final_beat = (idx_reg == burst_reg.last_idx);
    assign take       = busy_reg && ready;
    assign free       = !busy_reg || (ready && final_beat);

    // Step through the beats of the held group
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (take && final_beat)
        begin
            busy_reg <= 1'b0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    // Capture the group payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            burst_reg <= burst;
        end
    end

    assign valid           = busy_reg;
    assign out_byte        = burst_reg.bytes[idx_reg];
    assign dest_queue      = burst_reg.dest;
    assign head_code       = burst_reg.code;
    assign packet_len      = burst_reg.len;
    assign first_of_packet = burst_reg.has_first && (idx_reg == '0);
    assign last_of_packet  = burst_reg.has_last && final_beat;
    assign error_code      = burst_reg.err;

endmodule

/* hw/rtl/framed_packet_deframer_router.sv */
// Framed packet deframer and router.
// Slave stream: one received byte per beat in s_tdata, s_tlast marks the
// end of a receive chunk. Master stream: one packet byte per beat with its
// head code, length and connection index in m_tdata, the destination queue,
// first-byte flag and error code in m_tuser, and m_tlast on a packet's final
// byte. An APB port holds max_packet_len (0x0) and client_id (0x4).
// Header bytes are held until the head code arrives; that byte then yields
// three (short header) or four (long header) beats, every other byte at most
// one. The first result beat of an accepted byte is offered in the cycle after
// it is taken. Throughput is one byte per cycle while m_tready stays high; the
// single result register sets this; s_tready drops while a header group drains.
// A bad lead byte or length gives one error beat, and bytes are then dropped
// up to the end of the chunk.
// Reset clears the parser to expect a lead byte and empties the result
// register; the APB registers return to 8192 and 0.
// When the receiver stalls, the result beat holds and s_tready stays low
// until the last beat of the held group is taken.
module framed_packet_deframer_router (
    input  logic        clk,
    input  logic        rst_n,
    // APB
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // byte in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,   // chunk_end
    // packet byte out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] out_byte, [15:8] head_code,
                                   // [31:16] packet_len, [47:32] conn_id
    output logic [4:0]  m_tuser,   // [1:0] dest_queue, [2] first_of_packet,
                                   // [4:3] error_code
    output logic        m_tlast    // last_of_packet
);

    logic [15:0] max_len_reg;
    logic [15:0] client_id_reg;
    logic        cfg_wr;
    logic        step;
    logic        burst_load;
    fpdr_pkg::burst_t burst;
    logic [7:0]  out_byte;
    logic [1:0]  dest_queue;
    logic [7:0]  head_code;
    logic [15:0] packet_len;
    logic        first_of_packet;
    logic [1:0]  error_code;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg   <= fpdr_pkg::MAX_LEN_RESET;
            client_id_reg <= '0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == fpdr_pkg::REG_CLIENT_ID)
            begin
                client_id_reg <= pwdata[15:0];
            end
            else
            begin
                max_len_reg <= pwdata[15:0];
            end
        end
    end

    assign prdata = (paddr[2] == fpdr_pkg::REG_MAX_LEN) ? {16'd0, max_len_reg}
                                                        : {16'd0, client_id_reg};

    assign step = s_tvalid && s_tready;

    fpdr_parser u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .rx_byte        (s_tdata),
        .chunk_end      (s_tlast),
        .max_packet_len (max_len_reg),
        .burst_load     (burst_load),
        .burst          (burst)
    );

    fpdr_emitter u_emitter (
        .clk             (clk),
        .rst_n           (rst_n),
        .load            (step && burst_load),
        .burst           (burst),
        .free            (s_tready),
        .valid           (m_tvalid),
        .ready           (m_tready),
        .out_byte        (out_byte),
        .dest_queue      (dest_queue),
        .head_code       (head_code),
        .packet_len      (packet_len),
        .first_of_packet (first_of_packet),
        .last_of_packet  (m_tlast),
        .error_code      (error_code)
    );

    // Pack the result beat
    assign m_tdata = {client_id_reg, packet_len, head_code, out_byte};
    assign m_tuser = {error_code, first_of_packet, dest_queue};

endmodule

/* hw/rtl/fpdr_checker.sv */
`include "assert_macros.svh"

module fpdr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [4:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled result beat stays offered
    `ASSERT_CLK(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result beat dropped while stalled")

    // error beats go to the main queue and carry no first flag and no last flag
    `ASSERT_CLK(a_err_clean, m_tvalid && m_tuser[4:3] != fpdr_pkg::ERR_NONE |-> m_tuser[2:0] == 3'd0 && !m_tlast, "error beat carries packet flags")

    // a packet opens on a lead byte
    `ASSERT_CLK(a_first_lead, m_tvalid && m_tuser[2] |-> m_tdata[7:0] == fpdr_pkg::LEAD_SHORT || m_tdata[7:0] == fpdr_pkg::LEAD_LONG, "packet opens without lead byte")

    // a bad lead byte reports no length
    `ASSERT_CLK(a_lead_err_len, m_tvalid && m_tuser[4:3] == fpdr_pkg::ERR_LEAD |-> m_tdata[31:16] == 16'd0, "lead error with nonzero length")

    // nothing is offered after reset has been sampled low
    `ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !m_tvalid, "result offered during reset")

endmodule

bind framed_packet_deframer_router fpdr_checker u_fpdr_checker (.*);

/* verif/fpdr_stream_checker.sv */
`timescale 1ns / 1ps

module fpdr_stream_checker (
    input  logic        clk,
    input  logic        rst_n,
    // APB
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    // byte in
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    input  logic        s_tlast,   // chunk_end
    // packet byte out
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // [7:0] out_byte, [15:8] head_code,
                                   // [31:16] packet_len, [47:32] conn_id
    input  logic [4:0]  m_tuser,   // [1:0] dest_queue, [2] first_of_packet,
                                   // [4:3] error_code
    input  logic        m_tlast,   // last_of_packet
    output int          fail_count,
    output int          pending
);

    // Head codes that leave the main queue
    localparam logic [7:0] HC_52 = 8'h52;
    localparam logic [7:0] HC_54 = 8'h54;
    localparam logic [7:0] HC_55 = 8'h55;
    localparam logic [7:0] HC_F6 = 8'hF6;
    localparam logic [7:0] HC_F7 = 8'hF7;
    localparam logic [7:0] HC_13 = 8'h13;
    localparam logic [7:0] HC_14 = 8'h14;

    typedef struct packed {
        logic [7:0]  data;
        logic [1:0]  dest;
        logic [7:0]  code;
        logic [15:0] len;
        logic        first;
        logic        last;
        logic [1:0]  err;
        logic [15:0] conn;
    } pkt_beat_t;

    pkt_beat_t   beat_q[$];

    // Register copies
    logic [15:0] max_len_cfg;
    logic [15:0] conn_cfg;

    // Parser copy
    fpdr_pkg::phase_t phase;
    logic [7:0]  hdr_bytes [3];
    logic [15:0] pkt_len;
    logic [15:0] remaining;
    logic [1:0]  cur_dest;
    logic [7:0]  cur_code;
    logic        dropping;

    initial fail_count = 0;

    function automatic logic [1:0] queue_for_code(input logic [7:0] c);
        logic [1:0] q;
        q = fpdr_pkg::Q_MAIN;
        if (c == HC_52 || c == HC_54 || c == HC_55)
            q = fpdr_pkg::Q_52;
        else if (c == HC_F6 || c == HC_F7)
            q = fpdr_pkg::Q_F6;
        else if (c == HC_13 || c == HC_14)
            q = fpdr_pkg::Q_13;
        return q;
    endfunction

    task automatic add_beat(input logic [7:0] data, input logic [1:0] dest,
                            input logic [7:0] code, input logic [15:0] len,
                            input logic first, input logic last,
                            input logic [1:0] err);
        pkt_beat_t b;
        b.data  = data;
        b.dest  = dest;
        b.code  = code;
        b.len   = len;
        b.first = first;
        b.last  = last;
        b.err   = err;
        b.conn  = conn_cfg;
        beat_q.push_back(b);
    endtask

    // Emit one error beat and drop up to the chunk end unless this byte ends it
    task automatic flag_error(input logic [7:0] data, input logic [15:0] len,
                              input logic [1:0] err, input logic ce);
        add_beat(data, fpdr_pkg::Q_MAIN, 8'h00, len, 1'b0, 1'b0, err);
        phase    = fpdr_pkg::PH_LEAD;
        dropping = !ce;
    endtask

    task automatic check_length(input logic [7:0] data, input logic [15:0] hdr,
                                input logic ce);
        if (pkt_len < hdr || pkt_len > max_len_cfg)
            flag_error(data, pkt_len, fpdr_pkg::ERR_LEN, ce);
        else
            phase = fpdr_pkg::PH_CODE;
    endtask

    task automatic predict_byte(input logic [7:0] b, input logic ce);
        logic [15:0] hdr;
        if (dropping)
        begin
            // leave drop mode on the chunk end
            if (ce)
            begin
                dropping = 1'b0;
                phase    = fpdr_pkg::PH_LEAD;
            end
        end
        else
        begin
            case (phase)
                fpdr_pkg::PH_LEAD:
                begin
                    hdr_bytes[0] = b;
                    if (b == fpdr_pkg::LEAD_SHORT)
                        phase = fpdr_pkg::PH_LEN8;
                    else if (b == fpdr_pkg::LEAD_LONG)
                        phase = fpdr_pkg::PH_LENH;
                    else
                        flag_error(b, 16'h0000, fpdr_pkg::ERR_LEAD, ce);
                end
                fpdr_pkg::PH_LEN8:
                begin
                    hdr_bytes[1] = b;
                    pkt_len      = {8'h00, b};
                    check_length(b, fpdr_pkg::HDR_SHORT, ce);
                end
                fpdr_pkg::PH_LENH:
                begin
                    hdr_bytes[1] = b;
                    phase        = fpdr_pkg::PH_LENL;
                end
                fpdr_pkg::PH_LENL:
                begin
                    hdr_bytes[2] = b;
                    pkt_len      = {hdr_bytes[1], b};
                    check_length(b, fpdr_pkg::HDR_LONG, ce);
                end
                fpdr_pkg::PH_CODE:
                begin
                    // release the held header together with the head code
                    cur_code  = b;
                    cur_dest  = queue_for_code(b);
                    hdr       = (hdr_bytes[0] == fpdr_pkg::LEAD_LONG) ? fpdr_pkg::HDR_LONG
                                                                      : fpdr_pkg::HDR_SHORT;
                    remaining = pkt_len - hdr;
                    add_beat(hdr_bytes[0], cur_dest, cur_code, pkt_len, 1'b1, 1'b0,
                             fpdr_pkg::ERR_NONE);
                    add_beat(hdr_bytes[1], cur_dest, cur_code, pkt_len, 1'b0, 1'b0,
                             fpdr_pkg::ERR_NONE);
                    if (hdr == fpdr_pkg::HDR_LONG)
                        add_beat(hdr_bytes[2], cur_dest, cur_code, pkt_len, 1'b0, 1'b0,
                                 fpdr_pkg::ERR_NONE);
                    add_beat(b, cur_dest, cur_code, pkt_len, 1'b0, remaining == 0,
                             fpdr_pkg::ERR_NONE);
                    phase = (remaining == 0) ? fpdr_pkg::PH_LEAD : fpdr_pkg::PH_BODY;
                end
                default:
                begin
                    remaining = remaining - 16'd1;
                    add_beat(b, cur_dest, cur_code, pkt_len, 1'b0, remaining == 0,
                             fpdr_pkg::ERR_NONE);
                    if (remaining == 0)
                        phase = fpdr_pkg::PH_LEAD;
                end
            endcase
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_beat();
        pkt_beat_t want;
        if (beat_q.size() == 0)
        begin
            $error("unexpected result beat: out_byte %h", m_tdata[7:0]);
            fail_count++;
        end
        else
        begin
            want = beat_q.pop_front();
            check_field("out_byte", want.data, m_tdata[7:0]);
            check_field("dest_queue", want.dest, m_tuser[1:0]);
            check_field("head_code", want.code, m_tdata[15:8]);
            check_field("packet_len", want.len, m_tdata[31:16]);
            check_field("first_of_packet", want.first, m_tuser[2]);
            check_field("last_of_packet", want.last, m_tlast);
            check_field("error_code", want.err, m_tuser[4:3]);
            check_field("conn_id", want.conn, m_tdata[47:32]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_q.delete();
            max_len_cfg = fpdr_pkg::MAX_LEN_RESET;
            conn_cfg    = 16'h0000;
            phase       = fpdr_pkg::PH_LEAD;
            pkt_len     = 16'h0000;
            remaining   = 16'h0000;
            cur_dest    = fpdr_pkg::Q_MAIN;
            cur_code    = 8'h00;
            dropping    = 1'b0;
            pending    <= 0;
        end
        else
        begin
            // compare the result beat taken at this edge
            if (m_tvalid && m_tready)
                check_beat();
            // track register writes
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == fpdr_pkg::REG_CLIENT_ID)
                    conn_cfg = pwdata[15:0];
                else
                    max_len_cfg = pwdata[15:0];
            end
            // predict the results of the byte taken at this edge
            if (s_tvalid && s_tready)
                predict_byte(s_tdata, s_tlast);
            pending <= beat_q.size();
        end
    end

endmodule

/* verif/tb_framed_packet_deframer_router.sv */
`timescale 1ns / 1ps

module tb_framed_packet_deframer_router;

    localparam int LIMIT      = 200000;
    localparam int SETTLE_PAD = 6;

    localparam logic [2:0] ADDR_MAX_LEN   = {fpdr_pkg::REG_MAX_LEN, 2'b00};
    localparam logic [2:0] ADDR_CLIENT_ID = {fpdr_pkg::REG_CLIENT_ID, 2'b00};

    // Head codes that leave the main queue
    localparam logic [7:0] HC_52 = 8'h52;
    localparam logic [7:0] HC_54 = 8'h54;
    localparam logic [7:0] HC_55 = 8'h55;
    localparam logic [7:0] HC_F6 = 8'hF6;
    localparam logic [7:0] HC_F7 = 8'hF7;
    localparam logic [7:0] HC_13 = 8'h13;
    localparam logic [7:0] HC_14 = 8'h14;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] rx_byte
    logic        s_tlast;   // chunk_end
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [47:0] m_tdata;   // [7:0] out_byte, [15:8] head_code,
                            // [31:16] packet_len, [47:32] conn_id
    logic [4:0]  m_tuser;   // [1:0] dest_queue, [2] first_of_packet,
                            // [4:3] error_code
    logic        m_tlast;   // last_of_packet

    logic        steady = 1'b0;
    logic [15:0] max_len_now;
    int          fed;
    int          cycles = 0;
    int          fail_count;
    int          pending;

    framed_packet_deframer_router uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    fpdr_stream_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Stall the result side at random outside steady stretches
    always @(posedge clk)
        m_tready <= steady || ($urandom_range(99, 0) >= 8);

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic ce);
        if (!steady && $urandom_range(99, 0) < 8)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= ce;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Send a packet byte with a stray chunk end now and then
    task automatic feed(input logic [7:0] b);
        send_byte(b, $urandom_range(7, 0) == 0);
        fed++;
    endtask

    // Hold the sender until every expected beat has come
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_PAD) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'h0000, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] max_len, input logic [15:0] id);
        settle();
        apb_write(ADDR_MAX_LEN, max_len);
        apb_write(ADDR_CLIENT_ID, id);
        max_len_now = max_len;
    endtask

    function automatic logic [7:0] pick_code();
        logic [7:0] c;
        c = 8'($urandom);
        case ($urandom_range(13, 0))
            0: c = HC_52;
            1: c = HC_54;
            2: c = HC_55;
            3: c = HC_F6;
            4: c = HC_F7;
            5: c = HC_13;
            6: c = HC_14;
            default: ;
        endcase
        return c;
    endfunction

    // Well-formed packet with random content, mostly short
    task automatic send_packet();
        logic        long_hdr;
        logic [15:0] hdr;
        logic [15:0] len;
        int          top_len;
        logic [7:0]  body;
        long_hdr = (max_len_now >= fpdr_pkg::HDR_LONG) && ($urandom_range(1, 0) == 1);
        hdr      = long_hdr ? fpdr_pkg::HDR_LONG : fpdr_pkg::HDR_SHORT;
        top_len  = ($urandom_range(9, 0) == 0) ? hdr + 40 : hdr + 6;
        if (top_len > int'(max_len_now))
            top_len = int'(max_len_now);
        len = 16'($urandom_range(top_len, hdr));
        if (long_hdr)
        begin
            feed(fpdr_pkg::LEAD_LONG);
            feed(len[15:8]);
        end
        else
            feed(fpdr_pkg::LEAD_SHORT);
        feed(len[7:0]);
        feed(pick_code());
        repeat (len - hdr)
        begin
            body = 8'($urandom);
            feed(body);
        end
    endtask

    // Bad lead byte or bad length, then junk up to the chunk end
    task automatic send_broken();
        logic [7:0]  b;
        logic [15:0] len;
        logic        ce;
        logic        long_hdr;
        ce = ($urandom_range(3, 0) == 0);
        if ($urandom_range(1, 0) == 1)
        begin
            b = fpdr_pkg::LEAD_SHORT;
            while (b == fpdr_pkg::LEAD_SHORT || b == fpdr_pkg::LEAD_LONG)
                b = 8'($urandom);
            send_byte(b, ce);
            fed++;
        end
        else
        begin
            long_hdr = 1'($urandom_range(1, 0));
            if (long_hdr && max_len_now != 16'hFFFF && $urandom_range(1, 0) == 1)
                len = 16'($urandom_range(16'hFFFF, int'(max_len_now) + 1));
            else if (!long_hdr && max_len_now < 255 && $urandom_range(1, 0) == 1)
                len = 16'($urandom_range(255, int'(max_len_now) + 1));
            else
                len = 16'($urandom_range(long_hdr ? 3 : 2, 0));
            send_byte(long_hdr ? fpdr_pkg::LEAD_LONG : fpdr_pkg::LEAD_SHORT, 1'b0);
            fed++;
            if (long_hdr)
            begin
                send_byte(len[15:8], 1'b0);
                fed++;
            end
            send_byte(len[7:0], ce);
            fed++;
        end
        if (!ce)
        begin
            repeat ($urandom_range(4, 0))
            begin
                b = 8'($urandom);
                send_byte(b, 1'b0);
                fed++;
            end
            b = 8'($urandom);
            send_byte(b, 1'b1);
            fed++;
        end
    endtask

    task automatic run_random(input int n_items);
        int start;
        start = fed;
        while (fed - start < n_items)
        begin
            if (max_len_now >= fpdr_pkg::HDR_SHORT && $urandom_range(99, 0) < 70)
                send_packet();
            else
                send_broken();
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        fed         = 0;
        max_len_now = fpdr_pkg::MAX_LEN_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // shortest short packet, chunk end on its last byte is ignored
        send_byte(fpdr_pkg::LEAD_SHORT, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(HC_52, 1'b1);
        // long header with one body byte
        send_byte(fpdr_pkg::LEAD_LONG, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h05, 1'b0);
        send_byte(HC_F7, 1'b0);
        send_byte(8'hAA, 1'b0);
        // bad lead byte that ends its own chunk
        send_byte(8'h00, 1'b1);
        // bad lead byte, then drop up to the chunk end
        send_byte(8'hFF, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(fpdr_pkg::LEAD_SHORT, 1'b1);
        // length below the header size
        send_byte(fpdr_pkg::LEAD_SHORT, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h33, 1'b1);
        // length above the maximum, chunk end on the length byte
        send_byte(fpdr_pkg::LEAD_LONG, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        // packet spanning a chunk end
        send_byte(fpdr_pkg::LEAD_SHORT, 1'b0);
        send_byte(8'h04, 1'b1);
        send_byte(HC_13, 1'b0);
        send_byte(8'hFF, 1'b0);

        set_config(16'd4, 16'hFFFF);
        run_random(12);

        // no idling on either side through this phase
        steady <= 1'b1;
        set_config(16'hFFFF, 16'h0000);
        run_random(18);
        steady <= 1'b0;

        // maximum below the long header size
        set_config(16'd3, 16'h5A3C);
        run_random(10);

        set_config(16'd1000, 16'($urandom));
        run_random(12);
        settle();
        run_random(10);

        settle();
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
